// File: src/timed_motion_sequencer_pwm_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timed motion sequencer.
// Shared by every module that carries concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TIMED_MOTION_SEQUENCER_PWM_TOP_DEFINES_SVH
`define TIMED_MOTION_SEQUENCER_PWM_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

// File: src/tmspwm_pkg.sv
// ----------------------------------------------------------------------------
// Timed motion sequencer package
// Shared types, register indexes, step codes and direction codes.
// ----------------------------------------------------------------------------
package tmspwm_pkg;

   localparam int PWM_PERIOD_DEFAULT   = 100;
   localparam int TICKS_PER_MS_DEFAULT = 10;

   localparam int NUM_CMDS   = 4;
   localparam int CMD_W      = 25;
   localparam int DELAY_W    = 16;
   localparam int MS_W       = 16;
   localparam int DUTY_W     = 7;
   localparam int STEP_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CMD_SEL_W  = $clog2(NUM_CMDS);

   localparam int MS_LSB     = 9;
   localparam int DUTY_LSB   = 2;

   localparam logic [CMD_W-1:0]   CMD_RESET   = CMD_W'(256060);
   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(10000);

   localparam logic [CSR_IDX_W-1:0] REG_CMD_ONE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CMD_TWO     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CMD_THREE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CMD_FOUR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_START_DELAY = 3'd4;

   localparam logic [STEP_W-1:0] STEP_DELAY     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CMD_FIRST = 3'd1;
   localparam logic [STEP_W-1:0] STEP_CMD_LAST  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_DONE      = 3'd5;

   typedef enum logic [1:0] {
      DIR_CW  = 2'd0,
      DIR_CCW = 2'd1,
      DIR_FWD = 2'd2,
      DIR_REV = 2'd3
   } dir_type;

   typedef logic [CMD_W-1:0] cmd_type;

   typedef struct packed {
      cmd_type [NUM_CMDS-1:0] cmd;
      logic [DELAY_W-1:0]     start_delay;
   } cfg_type;

   typedef struct packed {
      logic              left_forward;
      logic              left_reverse;
      logic              right_forward;
      logic              right_reverse;
      logic [STEP_W-1:0] step_now;
   } res_type;

endpackage

// File: src/tmspwm_csr.sv
// ----------------------------------------------------------------------------
// Timed motion sequencer register file
// Holds the four motion commands and the start delay.
// ----------------------------------------------------------------------------
module tmspwm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tmspwm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tmspwm_pkg::CMD_W-1:0]     csr_wdata,
   output tmspwm_pkg::cfg_type              cfg
);
   import tmspwm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CMD_ONE:     cfg_in.cmd[0] = csr_wdata;
            REG_CMD_TWO:     cfg_in.cmd[1] = csr_wdata;
            REG_CMD_THREE:   cfg_in.cmd[2] = csr_wdata;
            REG_CMD_FOUR:    cfg_in.cmd[3] = csr_wdata;
            REG_START_DELAY: cfg_in.start_delay = csr_wdata[DELAY_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CMDS; i++) begin
            cfg_ff.cmd[i] <= CMD_RESET;
         end
         cfg_ff.start_delay <= DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// File: src/tmspwm_core.sv
// ----------------------------------------------------------------------------
// Timed motion sequencer core
// Step, tick and PWM phase counters with the motor pin decode.
// ----------------------------------------------------------------------------
`include "timed_motion_sequencer_pwm_top_defines.svh"

module tmspwm_core #(
   parameter int PWM_PERIOD   = tmspwm_pkg::PWM_PERIOD_DEFAULT,
   parameter int TICKS_PER_MS = tmspwm_pkg::TICKS_PER_MS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                run,
   input  tmspwm_pkg::cfg_type cfg,
   output tmspwm_pkg::res_type res
);
   import tmspwm_pkg::*;

   localparam int PHASE_W   = $clog2(PWM_PERIOD);
   localparam int CMP_W     = (PHASE_W > DUTY_W) ? PHASE_W : DUTY_W;
   localparam int ELAPSED_W = $clog2((2**MS_W - 1) * TICKS_PER_MS + 1);

   logic [STEP_W-1:0]    step_ff, step_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;

   logic [PHASE_W-1:0]   phase_inc;
   logic [ELAPSED_W-1:0] elapsed_inc;
   logic [ELAPSED_W-1:0] target;
   logic [CMD_SEL_W-1:0] cmd_sel;
   cmd_type              cmd;
   logic [MS_W-1:0]      cmd_ms;
   logic [DUTY_W-1:0]    cmd_duty;
   dir_type              cmd_dir;
   logic                 is_cmd;
   logic                 pin_on;
   logic                 step_end;

   always_comb begin
      phase_inc = (phase_ff == PHASE_W'(PWM_PERIOD - 1)) ? '0 : phase_ff + 1'b1;
      cmd_sel   = CMD_SEL_W'(step_ff - STEP_CMD_FIRST);
      cmd       = cfg.cmd[cmd_sel];
      cmd_ms    = cmd[MS_LSB +: MS_W];
      cmd_duty  = cmd[DUTY_LSB +: DUTY_W];
      cmd_dir   = dir_type'(cmd[1:0]);
      is_cmd    = (step_ff >= STEP_CMD_FIRST) && (step_ff <= STEP_CMD_LAST);
      pin_on    = run && is_cmd && (CMP_W'(phase_inc) < CMP_W'(cmd_duty));

      if (step_ff == STEP_DELAY) begin
         target = ELAPSED_W'(cfg.start_delay);
      end else begin
         target = ELAPSED_W'(cmd_ms) * ELAPSED_W'(TICKS_PER_MS);
      end
      elapsed_inc = elapsed_ff + 1'b1;
      step_end    = (step_ff != STEP_DONE) && (elapsed_inc >= target);

      step_in    = step_ff;
      elapsed_in = elapsed_ff;
      phase_in   = phase_ff;
      if (fire && run) begin
         phase_in = step_end ? '0 : phase_inc;
         if (step_ff != STEP_DONE) begin
            elapsed_in = step_end ? '0 : elapsed_inc;
            step_in    = step_end ? step_ff + 1'b1 : step_ff;
         end
      end

      res.left_forward  = pin_on && (cmd_dir == DIR_CCW || cmd_dir == DIR_FWD);
      res.left_reverse  = pin_on && !(cmd_dir == DIR_CCW || cmd_dir == DIR_FWD);
      res.right_forward = pin_on && (cmd_dir == DIR_CW || cmd_dir == DIR_FWD);
      res.right_reverse = pin_on && !(cmd_dir == DIR_CW || cmd_dir == DIR_FWD);
      res.step_now      = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_DELAY;
         elapsed_ff <= '0;
         phase_ff   <= '0;
      end else begin
         step_ff    <= step_in;
         elapsed_ff <= elapsed_in;
         phase_ff   <= phase_in;
      end
   end

   `TMS_ASSERT_NOW(a_phase_range, clock, reset, 1'b1, int'(phase_ff) < PWM_PERIOD)
   `TMS_ASSERT_NEXT(a_done_holds, clock, reset, step_ff == STEP_DONE, step_ff == STEP_DONE)
   `TMS_ASSERT_NOW(a_step_clears, clock, reset, !$stable(step_ff),
                   elapsed_ff == '0 && phase_ff == '0)

endmodule

// File: src/timed_motion_sequencer_pwm_top.sv
// ----------------------------------------------------------------------------
// Timed motion sequencer with two-motor PWM drive, top level
// A request beat is held in stage one; its result enters the output register when stage one fires.
// Throughput: one request beat per cycle while rsp_ready keeps the output register from stalling.
// Reset clears the sequence, pipeline valids and loads the register defaults.
// ----------------------------------------------------------------------------
`include "timed_motion_sequencer_pwm_top_defines.svh"

module timed_motion_sequencer_pwm_top #(
   parameter int PWM_PERIOD   = tmspwm_pkg::PWM_PERIOD_DEFAULT,
   parameter int TICKS_PER_MS = tmspwm_pkg::TICKS_PER_MS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_run,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_left_forward,
   output logic                             rsp_left_reverse,
   output logic                             rsp_right_forward,
   output logic                             rsp_right_reverse,
   output logic [tmspwm_pkg::STEP_W-1:0]    rsp_step_now,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tmspwm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tmspwm_pkg::CMD_W-1:0]     csr_wdata
);
   import tmspwm_pkg::*;

   cfg_type cfg;
   res_type res;

   logic    s1_valid_ff, s1_valid_in;
   logic    s1_run_ff;
   logic    out_valid_ff, out_valid_in;
   res_type out_res_ff;
   logic    s1_fire;
   logic    req_fire;

   tmspwm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tmspwm_core #(
      .PWM_PERIOD   (PWM_PERIOD),
      .TICKS_PER_MS (TICKS_PER_MS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (s1_fire),
      .run   (s1_run_ff),
      .cfg   (cfg),
      .res   (res)
   );

   always_comb begin
      s1_fire      = s1_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready    = !s1_valid_ff || s1_fire;
      req_fire     = req_valid && req_ready;
      s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
      out_valid_in = s1_fire || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_run_ff <= req_run;
      end
      if (s1_fire) begin
         out_res_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_left_forward  = out_res_ff.left_forward;
   assign rsp_left_reverse  = out_res_ff.left_reverse;
   assign rsp_right_forward = out_res_ff.right_forward;
   assign rsp_right_reverse = out_res_ff.right_reverse;
   assign rsp_step_now      = out_res_ff.step_now;

   `TMS_ASSERT_NOW(a_left_bridge, clock, reset, rsp_valid,
                   !(rsp_left_forward && rsp_left_reverse))
   `TMS_ASSERT_NOW(a_pins_in_cmd, clock, reset,
                   rsp_valid && (rsp_left_forward || rsp_left_reverse),
                   rsp_step_now >= STEP_CMD_FIRST && rsp_step_now <= STEP_CMD_LAST)

endmodule

// File: test/timed_motion_sequencer_pwm_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed motion sequencer testbench
// Drives run ticks through the sequencer and predicts every drive beat:
// the start delay, the four timed commands with their PWM duty and
// direction mapping, and the finished state. Both sides pause at random,
// the receiver holds off once to fill the block, and the registers are
// rewritten between phases, including while a command is under way.
// ----------------------------------------------------------------------------
module timed_motion_sequencer_pwm_top_test;
   import tmspwm_pkg::*;

   localparam int PWM          = PWM_PERIOD_DEFAULT;
   localparam int TICKS        = TICKS_PER_MS_DEFAULT;
   localparam int MS_MAX       = (1 << MS_W) - 1;
   localparam int DUTY_MAX     = (1 << DUTY_W) - 1;
   localparam int IDX_LAST     = (1 << CSR_IDX_W) - 1;
   localparam int RANDOM_LIMIT = 760;

   localparam int READY_ALWAYS  = 0;
   localparam int READY_RANDOM  = 1;
   localparam int READY_PATTERN = 2;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_run;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_left_forward;
   logic                 rsp_left_reverse;
   logic                 rsp_right_forward;
   logic                 rsp_right_reverse;
   logic [STEP_W-1:0]    rsp_step_now;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CMD_W-1:0]     csr_wdata;

   cmd_type              cmd_shadow [NUM_CMDS];
   logic [DELAY_W-1:0]   delay_shadow;
   logic [STEP_W-1:0]    seq_step;
   int                   seq_elapsed;
   int                   pwm_count;

   res_type              drive_queue [$];
   int                   ticks_sent = 0;
   int                   beats_checked = 0;
   int                   reg_writes = 0;
   int                   mismatch_count = 0;
   int                   longest_stall = 0;
   int                   burst_left = 0;
   int                   gaps_on = 0;
   int                   ready_mode = READY_ALWAYS;
   int                   hold_request = 0;
   logic [7:0]           steps_seen = '0;

   timed_motion_sequencer_pwm_top #(
      .PWM_PERIOD   (PWM),
      .TICKS_PER_MS (TICKS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_run           (req_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_right_forward (rsp_right_forward),
      .rsp_right_reverse (rsp_right_reverse),
      .rsp_step_now      (rsp_step_now),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic cmd_type pack_cmd(input int ms, input int duty, input dir_type dir);
      return {MS_W'(ms), DUTY_W'(duty), dir};
   endfunction

   function automatic int pick_duty();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return PWM - 1;
         2: return PWM;
         3: return DUTY_MAX;
         default: return $urandom_range(0, DUTY_MAX);
      endcase
   endfunction

   function automatic dir_type pick_dir();
      return dir_type'($urandom_range(DIR_CW, DIR_REV));
   endfunction

   // One tick of the sequence; returns the pin levels and the step that drove them.
   function automatic res_type advance_sequence(input logic run);
      res_type           drive;
      logic [STEP_W-1:0] now;
      cmd_type           cmd;
      int                target;
      drive = '0;
      now = seq_step;
      target = 0;
      if (run) begin
         pwm_count = (pwm_count + 1 >= PWM) ? 0 : pwm_count + 1;
         if (now == STEP_DELAY) begin
            target = delay_shadow;
         end else if (now <= STEP_CMD_LAST) begin
            cmd = cmd_shadow[now - STEP_CMD_FIRST];
            target = int'(cmd[CMD_W-1:MS_LSB]) * TICKS;
            if (pwm_count < int'(cmd[MS_LSB-1:DUTY_LSB])) begin
               case (dir_type'(cmd[DUTY_LSB-1:0]))
                  DIR_CW: begin
                     drive.left_reverse = 1'b1;
                     drive.right_forward = 1'b1;
                  end
                  DIR_CCW: begin
                     drive.left_forward = 1'b1;
                     drive.right_reverse = 1'b1;
                  end
                  DIR_FWD: begin
                     drive.left_forward = 1'b1;
                     drive.right_forward = 1'b1;
                  end
                  default: begin
                     drive.left_reverse = 1'b1;
                     drive.right_reverse = 1'b1;
                  end
               endcase
            end
         end
         if (now < STEP_DONE) begin
            seq_elapsed++;
            if (seq_elapsed >= target) begin
               seq_step = now + 1'b1;
               seq_elapsed = 0;
               pwm_count = 0;
            end
         end
      end
      drive.step_now = now;
      return drive;
   endfunction

   // Sends one tick beat, then keeps valid up for the burst or opens a gap.
   task automatic drive_tick(input logic run);
      int waited;
      waited = 0;
      req_valid <= 1'b1;
      req_run <= run;
      @(posedge clock);
      while (!req_ready) begin
         waited++;
         @(posedge clock);
      end
      drive_queue.push_back(advance_sequence(run));
      ticks_sent++;
      if (waited > longest_stall) longest_stall = waited;
      @(negedge clock);
      if (gaps_on != 0) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   task automatic random_tick();
      drive_tick($urandom_range(0, 6) != 0);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (drive_queue.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input cmd_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= REG_CMD_FOUR) cmd_shadow[idx] = data;
      else if (idx == REG_START_DELAY) delay_shadow = data[DELAY_W-1:0];
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_queue.size() == 0) begin
            $display("%0t: drive beat with nothing expected, step %0d", $time, rsp_step_now);
            mismatch_count++;
         end else begin
            want = drive_queue.pop_front();
            check_field("left_forward", want.left_forward, rsp_left_forward);
            check_field("left_reverse", want.left_reverse, rsp_left_reverse);
            check_field("right_forward", want.right_forward, rsp_right_forward);
            check_field("right_reverse", want.right_reverse, rsp_right_reverse);
            check_field("step_now", want.step_now, rsp_step_now);
         end
         beats_checked++;
         steps_seen[rsp_step_now] = 1'b1;
      end
   end

   initial begin
      int cyc;
      int hold_left;
      cyc = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (ready_mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
               default: rsp_ready <= !((cyc % 5 == 3) || (cyc % 7 == 0));
            endcase
         end
      end
   end

   task automatic test_reset_hold();
      repeat (2) drive_tick(1'b0);
      repeat (3) drive_tick(1'b1);
   endtask

   task automatic test_register_writes();
      wait_drain();
      write_reg(REG_CMD_ONE, pack_cmd(MS_MAX, DUTY_MAX, DIR_CW));
      write_reg(REG_CMD_TWO, CMD_W'($urandom));
      write_reg(REG_CMD_THREE, CMD_W'($urandom));
      write_reg(REG_CMD_FOUR, CMD_W'($urandom));
      for (int k = REG_START_DELAY + 1; k <= IDX_LAST; k++) write_reg(CSR_IDX_W'(k), '1);
      write_reg(REG_START_DELAY, '1);
      repeat (2) drive_tick(1'b1);
      wait_drain();
      write_reg(REG_START_DELAY, {{(CMD_W - DELAY_W){1'b1}}, {DELAY_W{1'b0}}});
      drive_tick(1'b1);
   endtask

   task automatic test_directions();
      for (int d = DIR_CW; d <= DIR_REV; d++) begin
         wait_drain();
         write_reg(REG_CMD_ONE, pack_cmd(MS_MAX, DUTY_MAX, dir_type'(d)));
         repeat (3) drive_tick(1'b1);
         wait_drain();
         write_reg(REG_CMD_ONE, pack_cmd(MS_MAX, 0, dir_type'(d)));
         drive_tick(1'b1);
      end
      drive_tick(1'b0);
   endtask

   task automatic test_random_motion();
      int phase;
      phase = 0;
      while (ticks_sent < RANDOM_LIMIT) begin
         wait_drain();
         ready_mode = $urandom_range(READY_ALWAYS, READY_PATTERN);
         gaps_on = (phase == 2) ? 0 : ($urandom_range(0, 3) != 0);
         write_reg(REG_CMD_ONE, pack_cmd($urandom_range(100, MS_MAX), pick_duty(), pick_dir()));
         if ($urandom_range(0, 2) == 0) begin
            write_reg(CSR_IDX_W'($urandom_range(REG_CMD_TWO, IDX_LAST)), CMD_W'($urandom));
         end
         if (phase == 2) begin
            hold_request = 150;
            repeat (60) drive_tick(1'b1);
         end else begin
            repeat ($urandom_range(10, 60)) random_tick();
         end
         phase++;
      end
   endtask

   task automatic test_step_through();
      wait_drain();
      ready_mode = READY_RANDOM;
      gaps_on = 1;
      write_reg(REG_CMD_TWO, pack_cmd($urandom_range(1, 3), pick_duty(), pick_dir()));
      write_reg(REG_CMD_THREE, pack_cmd(0, DUTY_MAX, pick_dir()));
      write_reg(REG_CMD_FOUR, pack_cmd($urandom_range(1, 3), pick_duty(), pick_dir()));
      // Command one is already past a zero length, so it ends on the next run tick.
      write_reg(REG_CMD_ONE, pack_cmd(0, pick_duty(), pick_dir()));
      while (seq_step != STEP_DONE) random_tick();
   endtask

   task automatic test_finished();
      repeat (10) random_tick();
      wait_drain();
      ready_mode = READY_PATTERN;
      write_reg(REG_START_DELAY, '0);
      write_reg(REG_CMD_ONE, pack_cmd(MS_MAX, DUTY_MAX, DIR_FWD));
      repeat (15) random_tick();
   endtask

   initial begin
      cmd_shadow = '{default: CMD_RESET};
      delay_shadow = DELAY_RESET;
      seq_step = STEP_DELAY;
      seq_elapsed = 0;
      pwm_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_run = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_hold();
      test_register_writes();
      test_directions();
      test_random_motion();
      test_step_through();
      test_finished();
      wait_drain();
      repeat (8) @(negedge clock);
      $display("Checked %0d drive beats of %0d ticks, %0d register writes, steps seen %b.",
               beats_checked, ticks_sent, reg_writes, steps_seen[STEP_DONE:STEP_DELAY]);
      $display("Longest input stall %0d cycles, %0d mismatches.", longest_stall, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS timed_motion_sequencer_pwm_top");
      end else begin
         $display("FAIL timed_motion_sequencer_pwm_top");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d beats still expected.", drive_queue.size());
      $display("FAIL timed_motion_sequencer_pwm_top");
      $finish;
   end

endmodule
